>>> sv/dga_pkg.sv
// Shared types, constants and helpers of the directional graph aggregate block.
package dga_pkg;

   localparam int FEATURE_BITS       = 16;
   localparam int FRACTION_BITS      = 10;
   localparam int ACC_BITS           = 32;
   localparam int COUNT_BITS         = 16;
   localparam int DIM_BITS           = 7;
   localparam int EMBED_DIMS_DEFAULT = 128;
   localparam int QUEUE_DEPTH        = 2;
   localparam int DIV_BITS           = 50;

   localparam logic [FEATURE_BITS-1:0] SAT_POS = {1'b0, {(FEATURE_BITS-1){1'b1}}};

   // One center beat handed from the front to the back.
   typedef struct packed {
      logic signed [ACC_BITS-1:0]     plain_sum;
      logic signed [ACC_BITS-1:0]     weighted_sum;
      logic signed [ACC_BITS-1:0]     eigen_weight;
      logic signed [ACC_BITS-1:0]     eigen_abs;
      logic [COUNT_BITS-1:0]          count;
      logic signed [FEATURE_BITS-1:0] feature;
      logic [DIM_BITS-1:0]            dim;
      logic                           last;
   } job_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_WORK
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MULT,
      BACK_MEAN,
      BACK_MEAN_WAIT,
      BACK_DERIV,
      BACK_DERIV_WAIT,
      BACK_DONE
   } back_state_type;

   // Saturate a widened sum to the signed accumulator range.
   function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS+1:0] x);
      logic signed [ACC_BITS+1:0] hi;
      logic signed [ACC_BITS+1:0] lo;
      hi = (ACC_BITS+2)'({1'b0, {(ACC_BITS-1){1'b1}}});
      lo = -hi - (ACC_BITS+2)'(1);
      if (x > hi) begin
         return hi[ACC_BITS-1:0];
      end else if (x < lo) begin
         return lo[ACC_BITS-1:0];
      end
      return x[ACC_BITS-1:0];
   endfunction

endpackage

>>> sv/dga_front.sv
// Front end: accepts beats, accumulates neighbor sums and totals, issues center jobs.
module dga_front #(
   parameter int EMBED_DIMS = dga_pkg::EMBED_DIMS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_is_center,
   input  logic [dga_pkg::DIM_BITS-1:0]            req_dim_index,
   input  logic                                    req_last_dim,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_feature_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_node_eigen_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_center_eigen_value,
   output logic                                    job_valid,
   input  logic                                    job_stall,
   output dga_pkg::job_type                        job
);

   localparam int ADDR_BITS = (EMBED_DIMS > 1) ? $clog2(EMBED_DIMS) : 1;
   localparam int ACC = dga_pkg::ACC_BITS;
   localparam int FB  = dga_pkg::FEATURE_BITS;

   dga_pkg::front_state_type state_ff, state_in;

   logic                          is_center_ff;
   logic [dga_pkg::DIM_BITS-1:0]  dim_ff;
   logic                          last_ff;
   logic signed [FB-1:0]          feat_ff, node_ff, ctr_ff;
   logic                          in_range_ff, rd_valid_ff;
   logic [ADDR_BITS-1:0]          addr_ff;
   logic signed [ACC-1:0]         plain_rd_ff, weighted_rd_ff;

   logic signed [ACC-1:0]         plain_mem [EMBED_DIMS];
   logic signed [ACC-1:0]         weighted_mem [EMBED_DIMS];
   logic [EMBED_DIMS-1:0]         valid_ff;

   logic signed [ACC-1:0]                  ewt_ff, eabs_ff;
   logic [dga_pkg::COUNT_BITS-1:0]         cnt_ff;

   logic                          accept, in_range_in, work_done, mem_write;
   logic [ADDR_BITS-1:0]          addr_in;
   logic signed [ACC-1:0]         psum, wsum, psum_new, wsum_new;
   logic signed [FB:0]            eig_w, eig_abs;
   logic signed [2*FB:0]          prod, prod_shift;

   assign req_stall   = (state_ff != dga_pkg::FRONT_IDLE);
   assign accept      = req_valid && (state_ff == dga_pkg::FRONT_IDLE);
   assign in_range_in = (32'(req_dim_index) < 32'(EMBED_DIMS));
   assign addr_in     = in_range_in ? ADDR_BITS'(req_dim_index) : '0;

   // Control state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dga_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a beat is held in the work state for the read-modify-write.
   always_comb begin
      state_in  = state_ff;
      work_done = 1'b0;
      case (state_ff)
         dga_pkg::FRONT_IDLE: begin
            if (accept) state_in = dga_pkg::FRONT_WORK;
         end
         dga_pkg::FRONT_WORK: begin
            work_done = !is_center_ff || !job_stall;
            if (work_done) state_in = dga_pkg::FRONT_IDLE;
         end
         default: state_in = dga_pkg::FRONT_IDLE;
      endcase
   end

   // Beat capture and registered memory read.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_center_ff   <= req_is_center;
         dim_ff         <= req_dim_index;
         last_ff        <= req_last_dim;
         feat_ff        <= req_feature_value;
         node_ff        <= req_node_eigen_value;
         ctr_ff         <= req_center_eigen_value;
         in_range_ff    <= in_range_in;
         addr_ff        <= addr_in;
         rd_valid_ff    <= valid_ff[addr_in];
         plain_rd_ff    <= plain_mem[addr_in];
         weighted_rd_ff <= weighted_mem[addr_in];
      end
      if (mem_write) begin
         plain_mem[addr_ff]    <= psum_new;
         weighted_mem[addr_ff] <= wsum_new;
      end
   end

   // Neighbor arithmetic on the held beat.
   always_comb begin
      psum       = (in_range_ff && rd_valid_ff) ? plain_rd_ff : '0;
      wsum       = (in_range_ff && rd_valid_ff) ? weighted_rd_ff : '0;
      eig_w      = (FB+1)'(node_ff) - (FB+1)'(ctr_ff);
      eig_abs    = (eig_w < 0) ? -eig_w : eig_w;
      prod       = (2*FB+1)'(feat_ff) * (2*FB+1)'(eig_w);
      prod_shift = prod >>> dga_pkg::FRACTION_BITS;
      psum_new   = dga_pkg::sat_acc((ACC+2)'(psum) + (ACC+2)'(feat_ff));
      wsum_new   = dga_pkg::sat_acc((ACC+2)'(wsum) + (ACC+2)'(prod_shift));
      mem_write  = (state_ff == dga_pkg::FRONT_WORK) && work_done && !is_center_ff
                   && in_range_ff;
   end

   // Entry valid bits: a cleared entry reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if ((state_ff == dga_pkg::FRONT_WORK) && work_done && in_range_ff) begin
         valid_ff[addr_ff] <= !is_center_ff;
      end
   end

   // Per-node totals and neighbor count.
   always_ff @(posedge clock) begin
      if (reset) begin
         ewt_ff  <= '0;
         eabs_ff <= '0;
         cnt_ff  <= '0;
      end else if ((state_ff == dga_pkg::FRONT_WORK) && work_done && last_ff) begin
         if (is_center_ff) begin
            ewt_ff  <= '0;
            eabs_ff <= '0;
            cnt_ff  <= '0;
         end else begin
            ewt_ff  <= dga_pkg::sat_acc((ACC+2)'(ewt_ff) + (ACC+2)'(eig_w));
            eabs_ff <= dga_pkg::sat_acc((ACC+2)'(eabs_ff) + (ACC+2)'(eig_abs));
            if (cnt_ff != '1) cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Center job snapshot.
   assign job_valid        = (state_ff == dga_pkg::FRONT_WORK) && is_center_ff;
   assign job.plain_sum    = psum;
   assign job.weighted_sum = wsum;
   assign job.eigen_weight = ewt_ff;
   assign job.eigen_abs    = eabs_ff;
   assign job.count        = cnt_ff;
   assign job.feature      = feat_ff;
   assign job.dim          = dim_ff;
   assign job.last         = last_ff;

endmodule

>>> sv/dga_queue.sv
// Short job queue between the front and the back.
module dga_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  dga_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop,
   output dga_pkg::job_type pop_job
);

   localparam int PTR_BITS = (dga_pkg::QUEUE_DEPTH > 1) ? $clog2(dga_pkg::QUEUE_DEPTH) : 1;

   dga_pkg::job_type              slot_ff [dga_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]             count_ff;
   logic                          do_push, do_pop;

   assign push_stall = (count_ff == (PTR_BITS+1)'(dga_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop && pop_valid;
   assign pop_job    = slot_ff[rd_ptr_ff];

   // Pointer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(dga_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(dga_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> sv/dga_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module dga_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dga_pkg::DIV_BITS-1:0]  dividend,
   input  logic [dga_pkg::ACC_BITS-1:0]  divisor,
   output logic                          done,
   output logic [dga_pkg::DIV_BITS-1:0]  quotient
);

   localparam int DW = dga_pkg::DIV_BITS;
   localparam int RW = dga_pkg::ACC_BITS;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, done_ff;
   logic [CW-1:0] count_ff;
   logic [DW-1:0] dvd_ff;
   logic [RW-1:0] rem_ff, den_ff;
   logic [RW:0]   rem_sh, diff;
   logic          ge;

   // One restoring step.
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DW-1]};
      diff   = rem_sh - {1'b0, den_ff};
      ge     = (rem_sh >= {1'b0, den_ff});
   end

   // Control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(DW);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DW-2:0], ge};
         rem_ff <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> sv/dga_back.sv
// Back end: forms the mean and directional derivative of each center job.
module dga_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    job_valid,
   output logic                                    job_pop,
   input  dga_pkg::job_type                        job,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_mean_value,
   output logic [dga_pkg::FEATURE_BITS-2:0]        rsp_deriv_value,
   output logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_center_value,
   output logic [dga_pkg::DIM_BITS-1:0]            rsp_out_dim,
   output logic                                    rsp_out_last,
   output logic                                    rsp_zero_divisor
);

   localparam int ACC = dga_pkg::ACC_BITS;
   localparam int FB  = dga_pkg::FEATURE_BITS;
   localparam int DW  = dga_pkg::DIV_BITS;
   localparam int PW  = ACC + FB;

   dga_pkg::back_state_type state_ff, state_in;
   dga_pkg::job_type        job_ff;
   logic signed [PW-1:0]    prod_ff;
   logic                    neg_ff, zdiv_ff;
   logic signed [FB-1:0]    mean_ff;
   logic [FB-2:0]           deriv_ff;
   logic                    rsp_valid_ff;

   logic                    div_start, div_done, out_load, mean_zero, deriv_zero;
   logic [DW-1:0]           div_dividend, div_quotient;
   logic [ACC-1:0]          div_divisor;
   logic [ACC:0]            mean_mag;
   logic signed [PW:0]      num;
   logic [PW:0]             num_mag;
   logic [FB:0]             mean_lim, mean_res;
   logic signed [FB:0]      mean_signed;

   dga_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Operand forming for both divisions.
   always_comb begin
      mean_zero   = (job_ff.count == '0);
      deriv_zero  = (job_ff.eigen_abs <= 0);
      mean_mag    = (job_ff.plain_sum < 0) ? (ACC+1)'(-(ACC+1)'(job_ff.plain_sum))
                                           : (ACC+1)'(job_ff.plain_sum);
      num         = (PW+1)'(job_ff.weighted_sum) - (PW+1)'(prod_ff >>> dga_pkg::FRACTION_BITS);
      num_mag     = (num < 0) ? $unsigned(-num) : $unsigned(num);
      mean_lim    = neg_ff ? (FB+1)'(dga_pkg::SAT_POS) + 1'b1 : (FB+1)'(dga_pkg::SAT_POS);
      mean_res    = (div_quotient > DW'(mean_lim)) ? mean_lim : div_quotient[FB:0];
      mean_signed = neg_ff ? -$signed(mean_res) : $signed(mean_res);
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dga_pkg::BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: fetch, multiply, two divisions, deliver.
   always_comb begin
      state_in     = state_ff;
      job_pop      = 1'b0;
      div_start    = 1'b0;
      div_dividend = DW'(mean_mag);
      div_divisor  = ACC'(job_ff.count);
      out_load     = 1'b0;
      case (state_ff)
         dga_pkg::BACK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               state_in = dga_pkg::BACK_MULT;
            end
         end
         dga_pkg::BACK_MULT: state_in = dga_pkg::BACK_MEAN;
         dga_pkg::BACK_MEAN: begin
            if (mean_zero) begin
               state_in = dga_pkg::BACK_DERIV;
            end else begin
               div_start = 1'b1;
               state_in  = dga_pkg::BACK_MEAN_WAIT;
            end
         end
         dga_pkg::BACK_MEAN_WAIT: begin
            if (div_done) state_in = dga_pkg::BACK_DERIV;
         end
         dga_pkg::BACK_DERIV: begin
            div_dividend = DW'(num_mag) << dga_pkg::FRACTION_BITS;
            div_divisor  = $unsigned(job_ff.eigen_abs);
            if (deriv_zero) begin
               state_in = dga_pkg::BACK_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = dga_pkg::BACK_DERIV_WAIT;
            end
         end
         dga_pkg::BACK_DERIV_WAIT: begin
            if (div_done) state_in = dga_pkg::BACK_DONE;
         end
         dga_pkg::BACK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = dga_pkg::BACK_IDLE;
            end
         end
         default: state_in = dga_pkg::BACK_IDLE;
      endcase
   end

   // Job datapath registers.
   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job;
      case (state_ff)
         dga_pkg::BACK_MULT: begin
            prod_ff <= PW'(job_ff.eigen_weight) * PW'(job_ff.feature);
            zdiv_ff <= mean_zero || deriv_zero;
            neg_ff  <= (job_ff.plain_sum < 0);
         end
         dga_pkg::BACK_MEAN: begin
            if (mean_zero) mean_ff <= '0;
         end
         dga_pkg::BACK_MEAN_WAIT: begin
            if (div_done) mean_ff <= mean_signed[FB-1:0];
         end
         dga_pkg::BACK_DERIV: begin
            if (deriv_zero) deriv_ff <= '0;
         end
         dga_pkg::BACK_DERIV_WAIT: begin
            if (div_done) begin
               deriv_ff <= (div_quotient > DW'(dga_pkg::SAT_POS)) ? dga_pkg::SAT_POS[FB-2:0]
                           : div_quotient[FB-2:0];
            end
         end
         default: ;
      endcase
   end

   // Output register: the result beat waits here while the next job starts.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mean_value   <= mean_ff;
         rsp_deriv_value  <= deriv_ff;
         rsp_center_value <= job_ff.feature;
         rsp_out_dim      <= job_ff.dim;
         rsp_out_last     <= job_ff.last;
         rsp_zero_divisor <= zdiv_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/directional_graph_aggregate_core.sv
// Top level of the directional graph aggregate block.
// Each beat carries one feature dimension. In the front end a neighbor beat gets a
// registered memory read, then an add and write back; a center beat gets the same read
// and is queued to the back end, which runs two bit-serial divisions of 50 steps each in
// the shared divider, skipping a division whose divisor is zero. A two-entry queue sits
// between the two ends, so neighbor beats keep flowing while the divider works, and the
// result register lets the back end start the next center job while a result waits.
module directional_graph_aggregate_core #(
   parameter int EMBED_DIMS = dga_pkg::EMBED_DIMS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_is_center,
   input  logic [dga_pkg::DIM_BITS-1:0]            req_dim_index,
   input  logic                                    req_last_dim,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_feature_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_node_eigen_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_center_eigen_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_mean_value,
   output logic [dga_pkg::FEATURE_BITS-2:0]        rsp_deriv_value,
   output logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_center_value,
   output logic [dga_pkg::DIM_BITS-1:0]            rsp_out_dim,
   output logic                                    rsp_out_last,
   output logic                                    rsp_zero_divisor
);

   logic             push_valid, push_stall, pop_valid, pop;
   dga_pkg::job_type push_job, pop_job;

   dga_front #(.EMBED_DIMS(EMBED_DIMS)) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_is_center          (req_is_center),
      .req_dim_index          (req_dim_index),
      .req_last_dim           (req_last_dim),
      .req_feature_value      (req_feature_value),
      .req_node_eigen_value   (req_node_eigen_value),
      .req_center_eigen_value (req_center_eigen_value),
      .job_valid              (push_valid),
      .job_stall              (push_stall),
      .job                    (push_job)
   );

   dga_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   dga_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (pop_valid),
      .job_pop          (pop),
      .job              (pop_job),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_deriv_value  (rsp_deriv_value),
      .rsp_center_value (rsp_center_value),
      .rsp_out_dim      (rsp_out_dim),
      .rsp_out_last     (rsp_out_last),
      .rsp_zero_divisor (rsp_zero_divisor)
   );

endmodule

>>> sim/dga_checker.sv
// Checker that predicts and compares the results of the directional graph aggregate block.
`timescale 1ns / 1ps

module dga_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic                                    req_is_center,
   input  logic [dga_pkg::DIM_BITS-1:0]            req_dim_index,
   input  logic                                    req_last_dim,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_feature_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_node_eigen_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] req_center_eigen_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_mean_value,
   input  logic [dga_pkg::FEATURE_BITS-2:0]        rsp_deriv_value,
   input  logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_center_value,
   input  logic [dga_pkg::DIM_BITS-1:0]            rsp_out_dim,
   input  logic                                    rsp_out_last,
   input  logic                                    rsp_zero_divisor,
   output int                                      fail_count,
   output int                                      pending_count
);

   localparam int DIMS = dga_pkg::EMBED_DIMS_DEFAULT;
   localparam longint SAT_HI = (64'sd1 <<< (dga_pkg::FEATURE_BITS - 1)) - 1;
   localparam longint ACC_HI = 64'sd2147483647;
   localparam longint ACC_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [15:0] mean;
      logic [14:0]        deriv;
      logic signed [15:0] center;
      logic [6:0]         dim;
      logic               last;
      logic               zdiv;
   } aggregate_result_type;

   longint plain_sums[DIMS];
   longint weighted_sums[DIMS];
   longint eigen_total;
   longint eigen_abs;
   int     degree;
   aggregate_result_type pending_results[$];

   function automatic longint clamp_acc(input longint x);
      if (x > ACC_HI) return ACC_HI;
      if (x < ACC_LO) return ACC_LO;
      return x;
   endfunction

   // Arithmetic shift rounds toward minus infinity.
   function automatic longint shift_down(input longint x);
      return x >>> dga_pkg::FRACTION_BITS;
   endfunction

   // Scaled division truncating toward zero, clamped to the feature range.
   function automatic longint scaled_quotient(input longint num, input longint den,
                                              input int s);
      longint mag;
      longint lim;
      longint q;
      longint r;
      longint res;
      mag = (num < 0) ? -num : num;
      lim = (num < 0) ? SAT_HI + 1 : SAT_HI;
      q = mag / den;
      r = mag % den;
      if (q > (lim >>> s)) res = lim;
      else begin
         res = (q <<< s) + ((r <<< s) / den);
         if (res > lim) res = lim;
      end
      return (num < 0) ? -res : res;
   endfunction

   task automatic aggregate_beat();
      longint feat;
      longint eig_w;
      longint mean;
      longint deriv;
      longint num;
      aggregate_result_type r;
      feat = req_feature_value;
      eig_w = longint'(req_node_eigen_value) - longint'(req_center_eigen_value);
      if (!req_is_center) begin
         plain_sums[req_dim_index] = clamp_acc(plain_sums[req_dim_index] + feat);
         weighted_sums[req_dim_index] =
            clamp_acc(weighted_sums[req_dim_index] + shift_down(feat * eig_w));
         if (req_last_dim) begin
            eigen_total = clamp_acc(eigen_total + eig_w);
            eigen_abs = clamp_acc(eigen_abs + ((eig_w < 0) ? -eig_w : eig_w));
            if (degree != 65535) degree++;
         end
         return;
      end
      mean = 0;
      deriv = 0;
      r.zdiv = 1'b0;
      if (degree == 0) r.zdiv = 1'b1;
      else mean = scaled_quotient(plain_sums[req_dim_index], degree, 0);
      if (eigen_abs <= 0) r.zdiv = 1'b1;
      else begin
         num = weighted_sums[req_dim_index] - shift_down(eigen_total * feat);
         deriv = scaled_quotient(num, eigen_abs, dga_pkg::FRACTION_BITS);
         if (deriv < 0) deriv = -deriv;
         if (deriv > SAT_HI) deriv = SAT_HI;
      end
      r.mean = mean[15:0];
      r.deriv = deriv[14:0];
      r.center = req_feature_value;
      r.dim = req_dim_index;
      r.last = req_last_dim;
      pending_results.push_back(r);
      plain_sums[req_dim_index] = 0;
      weighted_sums[req_dim_index] = 0;
      if (req_last_dim) begin
         eigen_total = 0;
         eigen_abs = 0;
         degree = 0;
      end
   endtask

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      aggregate_result_type e;
      if (reset) begin
         foreach (plain_sums[i]) begin
            plain_sums[i] = 0;
            weighted_sums[i] = 0;
         end
         eigen_total = 0;
         eigen_abs = 0;
         degree = 0;
         pending_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat dim %0d", $time, rsp_out_dim);
               fail_count++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_mean_value !== e.mean || rsp_deriv_value !== e.deriv ||
                   rsp_center_value !== e.center || rsp_out_dim !== e.dim ||
                   rsp_out_last !== e.last || rsp_zero_divisor !== e.zdiv) begin
                  $display({"%0t: mismatch expected mean %0d deriv %0d center %0d",
                            " dim %0d last %0d zdiv %0d"},
                           $time, e.mean, e.deriv, e.center, e.dim, e.last, e.zdiv);
                  $display({"%0t:          actual mean %0d deriv %0d center %0d",
                            " dim %0d last %0d zdiv %0d"},
                           $time, rsp_mean_value, rsp_deriv_value, rsp_center_value,
                           rsp_out_dim, rsp_out_last, rsp_zero_divisor);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) aggregate_beat();
      end
      pending_count = pending_results.size();
   end
endmodule

>>> sim/tb_top.sv
// Testbench top that drives the directional graph aggregate block and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_is_center;
   logic [dga_pkg::DIM_BITS-1:0] req_dim_index;
   logic req_last_dim;
   logic signed [dga_pkg::FEATURE_BITS-1:0] req_feature_value;
   logic signed [dga_pkg::FEATURE_BITS-1:0] req_node_eigen_value;
   logic signed [dga_pkg::FEATURE_BITS-1:0] req_center_eigen_value;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_mean_value;
   logic [dga_pkg::FEATURE_BITS-2:0] rsp_deriv_value;
   logic signed [dga_pkg::FEATURE_BITS-1:0] rsp_center_value;
   logic [dga_pkg::DIM_BITS-1:0] rsp_out_dim;
   logic rsp_out_last;
   logic rsp_zero_divisor;
   int fail_count;
   int pending_count;
   int beats_sent;
   bit calm_phase;

   directional_graph_aggregate_core uut (.*);
   dga_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("directional_graph_aggregate_core verification failed");
      $finish;
   end

   // Random result-side stall bursts, none in the calm phase.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm_phase && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Send one beat, then hold it until it is accepted.
   task automatic send_beat(input bit center, input int dim, input bit last,
                            input logic signed [15:0] feat, input logic signed [15:0] node_e,
                            input logic signed [15:0] ctr_e);
      int n;
      if (!calm_phase && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 18);
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_is_center = center;
      req_dim_index = dim[dga_pkg::DIM_BITS-1:0];
      req_last_dim = last;
      req_feature_value = feat;
      req_node_eigen_value = node_e;
      req_center_eigen_value = ctr_e;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   // One node: neighbors over dims 0..dims-1, then the center row.
   task automatic send_node(input int dims, input int neighbors, input bit extreme);
      logic signed [15:0] ce;
      ce = extreme ? 16'sh8000 : pick_value();
      for (int k = 0; k < neighbors; k++)
         for (int d = 0; d < dims; d++)
            send_beat(1'b0, d, d == dims - 1, extreme ? 16'sh7fff : pick_value(),
                      extreme ? 16'sh7fff : pick_value(), ce);
      for (int d = 0; d < dims; d++)
         send_beat(1'b1, d, d == dims - 1, pick_value(), pick_value(), ce);
   endtask

   initial begin
      int waited;
      calm_phase = 1'b0;
      beats_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_is_center = 1'b0;
      req_dim_index = '0;
      req_last_dim = 1'b0;
      req_feature_value = '0;
      req_node_eigen_value = '0;
      req_center_eigen_value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: center with no neighbors, equal eigens, extremes, high dims.
      send_beat(1'b1, 0, 1'b1, 16'sh7fff, 0, 0);
      send_beat(1'b0, 127, 1'b1, 16'sh1234, 16'sh0400, 16'sh0400);
      send_beat(1'b1, 127, 1'b1, 16'sh8000, 0, 16'sh0400);
      send_node(2, 3, 1'b1);
      send_node(1, 4, 1'b1);
      send_beat(1'b0, 5, 1'b1, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_beat(1'b0, 5, 1'b1, -16'sd1, 16'sh7fff, 16'sh8000);
      send_beat(1'b1, 5, 1'b1, 16'sh7fff, 0, 16'sh7fff);

      // Random nodes, mostly well formed, a few stray beats.
      while (beats_sent < 1700) begin
         if (beats_sent > 1400) calm_phase = 1'b1;
         if ($urandom_range(0, 9) == 0)
            send_beat($urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 1),
                      pick_value(), pick_value(), pick_value());
         else
            send_node($urandom_range(1, 6), $urandom_range(0, 5), $urandom_range(0, 15) == 0);
      end
      req_valid = 1'b0;

      waited = 0;
      while (pending_count != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("directional_graph_aggregate_core verification clean");
      else
         $display("directional_graph_aggregate_core verification failed");
      $finish;
   end
endmodule

>>> files.f
sv/dga_pkg.sv
sv/dga_front.sv
sv/dga_queue.sv
sv/dga_div.sv
sv/dga_back.sv
sv/directional_graph_aggregate_core.sv
sim/dga_checker.sv
sim/tb_top.sv
